[design/ptp_pkg.sv]
package ptp_pkg;

    // kinds of input beat
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    // register offsets, write bit stripped
    localparam logic [5:0] ADDR_LPS = 6'o14;
    localparam logic [5:0] ADDR_LPB = 6'o16;
    localparam logic [5:0] ADDR_PRS = 6'o50;
    localparam logic [5:0] ADDR_PRB = 6'o52;
    localparam logic [5:0] ADDR_PPS = 6'o54;
    localparam logic [5:0] ADDR_PPB = 6'o56;

    // status bits and masks
    localparam logic [15:0] BIT_ERR      = 16'o100000;
    localparam logic [15:0] BIT_BUSY     = 16'o004000;
    localparam logic [15:0] BIT_DONE     = 16'o000200;
    localparam logic [15:0] BIT_GO       = 16'o000001;
    localparam logic [15:0] KEEP_RO      = 16'o100200;
    localparam logic [15:0] WR_STAT      = 16'o077577;
    localparam logic [15:0] KEEP_PRS     = 16'o177676;
    localparam logic [15:0] WR_PRS       = 16'o000101;
    localparam logic [15:0] PRELOAD      = 16'o000123;
    localparam logic [15:0] CLR_BUSY_GO  = ~16'o004001;

    // one input beat
    typedef struct packed {
        func_t       func;
        logic [5:0]  reg_addr;
        logic [15:0] write_data;
        logic [7:0]  reader_byte;
        logic        reader_ok;
        logic        punch_ok;
        logic        printer_ok;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [15:0] read_data;
        logic        reader_consumed;
        logic        punch_valid;
        logic [7:0]  punch_byte;
        logic        printer_valid;
        logic [7:0]  printer_byte;
    } result_t;

endpackage

[design/ptp_core.sv]
module ptp_core
    import ptp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  item_t   item,
    output result_t result
);

    logic [15:0] rs_reg, rs_next;
    logic [15:0] rb_reg, rb_next;
    logic [15:0] ps_reg, ps_next;
    logic [15:0] pb_reg, pb_next;
    logic [15:0] ls_reg, ls_next;
    logic [15:0] lb_reg, lb_next;
    logic        pend_reg, pend_next;

    // register file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg   <= '0;
            rb_reg   <= '0;
            ps_reg   <= BIT_DONE;
            pb_reg   <= '0;
            ls_reg   <= BIT_DONE;
            lb_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else if (go)
        begin
            rs_reg   <= rs_next;
            rb_reg   <= rb_next;
            ps_reg   <= ps_next;
            pb_reg   <= pb_next;
            ls_reg   <= ls_next;
            lb_reg   <= lb_next;
            pend_reg <= pend_next;
        end
    end

    // next state and result for the beat in the input register
    always_comb
    begin
        logic [15:0] r;
        rs_next   = rs_reg;
        rb_next   = rb_reg;
        ps_next   = ps_reg;
        pb_next   = pb_reg;
        ls_next   = ls_reg;
        lb_next   = lb_reg;
        pend_next = pend_reg;
        result    = '0;
        r         = '0;
        unique case (item.func)
            FUNC_READ:
            begin
                unique case (item.reg_addr)
                    ADDR_LPS: result.read_data = ls_reg;
                    ADDR_LPB: result.read_data = lb_reg;
                    ADDR_PRS: result.read_data = pend_reg ? BIT_BUSY : rs_reg;
                    ADDR_PRB:
                    begin
                        result.read_data = rb_reg;
                        rs_next          = rs_reg & ~BIT_DONE;
                    end
                    ADDR_PPS: result.read_data = pend_reg ? 16'h0000 : ps_reg;
                    ADDR_PPB: result.read_data = pb_reg;
                    default:  result.read_data = 16'h0000;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (item.reg_addr)
                    ADDR_LPS: ls_next = (ls_reg & KEEP_RO) | (item.write_data & WR_STAT);
                    ADDR_LPB:
                    begin
                        lb_next = item.write_data;
                        ls_next = ls_reg & ~BIT_DONE;
                    end
                    ADDR_PRS:
                    begin
                        r = (rs_reg & KEEP_PRS) | (item.write_data & WR_PRS);
                        if ((r & BIT_GO) != 16'h0000)
                        begin
                            r       = (r & ~BIT_DONE) | BIT_BUSY;
                            rb_next = PRELOAD;
                        end
                        rs_next = r;
                    end
                    ADDR_PPS: ps_next = (ps_reg & KEEP_RO) | (item.write_data & WR_STAT);
                    ADDR_PPB:
                    begin
                        pb_next = item.write_data;
                        ps_next = ps_reg & ~BIT_DONE;
                    end
                    default:  rs_next = rs_reg;
                endcase
            end
            FUNC_RESET:
            begin
                pend_next = 1'b1;
            end
            FUNC_TICK:
            begin
                if (pend_reg)
                begin
                    rs_next   = '0;
                    ps_next   = BIT_DONE;
                    ls_next   = BIT_DONE;
                    pend_next = 1'b0;
                end
                else
                begin
                    // reader fetch
                    if ((rs_reg & BIT_GO) != 16'h0000)
                    begin
                        r = (rs_reg & CLR_BUSY_GO) | BIT_DONE;
                        if (item.reader_ok)
                        begin
                            rb_next                = {rb_reg[15:8], item.reader_byte};
                            result.reader_consumed = 1'b1;
                        end
                        else
                        begin
                            r = r | BIT_ERR;
                        end
                        rs_next = r;
                    end
                    // punch output
                    if ((ps_reg & BIT_DONE) == 16'h0000)
                    begin
                        if (item.punch_ok)
                        begin
                            result.punch_valid = 1'b1;
                            result.punch_byte  = pb_reg[7:0];
                            ps_next            = ps_reg | BIT_DONE;
                        end
                        else
                        begin
                            ps_next = ps_reg | BIT_ERR | BIT_DONE;
                        end
                    end
                    // printer output
                    if ((ls_reg & BIT_DONE) == 16'h0000)
                    begin
                        if (item.printer_ok)
                        begin
                            result.printer_valid = 1'b1;
                            result.printer_byte  = lb_reg[7:0];
                            ls_next              = ls_reg | BIT_DONE;
                        end
                        else
                        begin
                            ls_next = ls_reg | BIT_ERR | BIT_DONE;
                        end
                    end
                end
            end
        endcase
    end

    // pending reset flag follows request and service beats
    a_req_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.func == FUNC_RESET |=> pend_reg)
        else $error("reset request did not raise pending flag");

    a_tick_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.func == FUNC_TICK && pend_reg |=> !pend_reg && ps_reg == BIT_DONE
        && ls_reg == BIT_DONE && rs_reg == 16'h0000)
        else $error("pending reset tick left wrong status");

    a_pend_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item.func == FUNC_TICK && pend_reg |-> !result.reader_consumed
        && !result.punch_valid && !result.printer_valid)
        else $error("pending reset tick emitted output");

endmodule

[design/paper_tape_printer_register_block_unit.sv]
// a beat accepted into the input register moves through the core into the result register
// throughput: one beat per cycle; the input register and the result register
// both move when the result register is empty or being taken
// reset: rst_n is asynchronous active low; it empties both registers, clears the
// pending flag and sets punch and printer status to ready, other core registers to zero
module paper_tape_printer_register_block_unit
    import ptp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [5:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic [7:0]  reader_byte,
    input  logic        reader_ok,
    input  logic        punch_ok,
    input  logic        printer_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        reader_consumed,
    output logic        punch_valid,
    output logic [7:0]  punch_byte,
    output logic        printer_valid,
    output logic [7:0]  printer_byte
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    move;

    // the input beat moves on when the result slot is free or draining
    assign move     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !move;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            item_reg     <= '0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
            if (in_valid)
            begin
                item_reg <= '{func:        func_t'(func),
                              reg_addr:    reg_addr,
                              write_data:  write_data,
                              reader_byte: reader_byte,
                              reader_ok:   reader_ok,
                              punch_ok:    punch_ok,
                              printer_ok:  printer_ok};
            end
        end
    end

    ptp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (move),
        .item   (item_reg),
        .result (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = res_reg.read_data;
    assign reader_consumed = res_reg.reader_consumed;
    assign punch_valid     = res_reg.punch_valid;
    assign punch_byte      = res_reg.punch_byte;
    assign printer_valid   = res_reg.printer_valid;
    assign printer_byte    = res_reg.printer_byte;

    // a moved beat always lands in the result register
    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("moved beat lost");

    // an empty result slot never holds back the input side
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("stall with empty result register");

    // tick outputs and read data are exclusive
    a_tick_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (reader_consumed || punch_valid || printer_valid)
        |-> read_data == 16'h0000)
        else $error("read data on a service beat");

endmodule

[test/ptp_register_checker.sv]
module ptp_register_checker
    import ptp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [5:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic [7:0]  reader_byte,
    input  logic        reader_ok,
    input  logic        punch_ok,
    input  logic        printer_ok,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] read_data,
    input  logic        reader_consumed,
    input  logic        punch_valid,
    input  logic [7:0]  punch_byte,
    input  logic        printer_valid,
    input  logic [7:0]  printer_byte,
    output int          mismatch_count,
    output int          outstanding
);

    // shadow copy of the six device registers and the pending reset flag
    logic [15:0] prs_q;
    logic [15:0] prb_q;
    logic [15:0] pps_q;
    logic [15:0] ppb_q;
    logic [15:0] lps_q;
    logic [15:0] lpb_q;
    logic        reset_req_q;

    result_t pending_results[$];

    // bus read side, including the side effect on reader done
    function automatic logic [15:0] read_register(logic [5:0] addr);
        case (addr)
            ADDR_LPS: return lps_q;
            ADDR_LPB: return lpb_q;
            ADDR_PRS: return reset_req_q ? BIT_BUSY : prs_q;
            ADDR_PRB:
            begin
                prs_q = prs_q & ~BIT_DONE;
                return prb_q;
            end
            ADDR_PPS: return reset_req_q ? 16'h0000 : pps_q;
            ADDR_PPB: return ppb_q;
            default:  return 16'h0000;
        endcase
    endfunction

    // bus write side, honoring the read-only bits
    function automatic void write_register(logic [5:0] addr, logic [15:0] data);
        logic [15:0] nxt;
        case (addr)
            ADDR_LPS: lps_q = (lps_q & KEEP_RO) | (data & WR_STAT);
            ADDR_LPB:
            begin
                lpb_q = data;
                lps_q = lps_q & ~BIT_DONE;
            end
            ADDR_PRS:
            begin
                nxt = (prs_q & KEEP_PRS) | (data & WR_PRS);
                // go starts a fetch and preloads the buffer
                if ((nxt & BIT_GO) != 16'h0000)
                begin
                    nxt   = (nxt & ~BIT_DONE) | BIT_BUSY;
                    prb_q = PRELOAD;
                end
                prs_q = nxt;
            end
            ADDR_PPS: pps_q = (pps_q & KEEP_RO) | (data & WR_STAT);
            ADDR_PPB:
            begin
                ppb_q = data;
                pps_q = pps_q & ~BIT_DONE;
            end
            default: ;
        endcase
    endfunction

    // expected result beat for one input beat, state updated in place
    function automatic result_t predict_access(item_t beat);
        result_t     res;
        logic [15:0] nxt;
        res = '0;
        case (beat.func)
            FUNC_READ:  res.read_data = read_register(beat.reg_addr);
            FUNC_WRITE: write_register(beat.reg_addr, beat.write_data);
            FUNC_RESET: reset_req_q = 1'b1;
            default:
            begin
                if (reset_req_q)
                begin
                    // deferred reset: status back to idle, buffers kept
                    prs_q       = 16'h0000;
                    pps_q       = BIT_DONE;
                    lps_q       = BIT_DONE;
                    reset_req_q = 1'b0;
                end
                else
                begin
                    // reader fetch completes
                    if ((prs_q & BIT_GO) != 16'h0000)
                    begin
                        nxt = (prs_q & CLR_BUSY_GO) | BIT_DONE;
                        if (beat.reader_ok)
                        begin
                            prb_q               = {prb_q[15:8], beat.reader_byte};
                            res.reader_consumed = 1'b1;
                        end
                        else
                        begin
                            nxt = nxt | BIT_ERR;
                        end
                        prs_q = nxt;
                    end
                    // punch output
                    if ((pps_q & BIT_DONE) == 16'h0000)
                    begin
                        if (beat.punch_ok)
                        begin
                            res.punch_valid = 1'b1;
                            res.punch_byte  = ppb_q[7:0];
                        end
                        else
                        begin
                            pps_q = pps_q | BIT_ERR;
                        end
                        pps_q = pps_q | BIT_DONE;
                    end
                    // printer output
                    if ((lps_q & BIT_DONE) == 16'h0000)
                    begin
                        if (beat.printer_ok)
                        begin
                            res.printer_valid = 1'b1;
                            res.printer_byte  = lpb_q[7:0];
                        end
                        else
                        begin
                            lps_q = lps_q | BIT_ERR;
                        end
                        lps_q = lps_q | BIT_DONE;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare result beats first, then predict the input beat of this edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        item_t   beat;
        if (!rst_n)
        begin
            prs_q          = 16'h0000;
            prb_q          = 16'h0000;
            pps_q          = BIT_DONE;
            ppb_q          = 16'h0000;
            lps_q          = BIT_DONE;
            lpb_q          = 16'h0000;
            reset_req_q    = 1'b0;
            mismatch_count = 0;
            pending_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got read_data %h",
                             $time, read_data);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("reader_consumed", 16'(want.reader_consumed),
                                16'(reader_consumed));
                    check_field("punch_valid", 16'(want.punch_valid), 16'(punch_valid));
                    check_field("punch_byte", 16'(want.punch_byte), 16'(punch_byte));
                    check_field("printer_valid", 16'(want.printer_valid),
                                16'(printer_valid));
                    check_field("printer_byte", 16'(want.printer_byte), 16'(printer_byte));
                end
            end
            if (in_valid && !in_stall)
            begin
                beat = {func, reg_addr, write_data, reader_byte, reader_ok, punch_ok,
                        printer_ok};
                pending_results.push_back(predict_access(beat));
            end
        end
        outstanding = pending_results.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    import ptp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [5:0]  reg_addr;
    logic [15:0] write_data;
    logic [7:0]  reader_byte;
    logic        reader_ok;
    logic        punch_ok;
    logic        printer_ok;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] read_data;
    logic        reader_consumed;
    logic        punch_valid;
    logic [7:0]  punch_byte;
    logic        printer_valid;
    logic [7:0]  printer_byte;

    int mismatch_count;
    int outstanding;
    int idle_cycles;
    bit idle_on;
    bit hold_req;

    paper_tape_printer_register_block_unit u_top (.*);

    ptp_register_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [5:0] any_register();
        case ($urandom_range(0, 5))
            0:       return ADDR_LPS;
            1:       return ADDR_LPB;
            2:       return ADDR_PRS;
            3:       return ADDR_PRB;
            4:       return ADDR_PPS;
            default: return ADDR_PPB;
        endcase
    endfunction

    // bus beat with the tick-only fields left random
    function automatic item_t bus_beat(func_t f, logic [5:0] addr, logic [15:0] data);
        item_t b;
        b.func        = f;
        b.reg_addr    = addr;
        b.write_data  = data;
        b.reader_byte = 8'($urandom);
        b.reader_ok   = 1'($urandom);
        b.punch_ok    = 1'($urandom);
        b.printer_ok  = 1'($urandom);
        return b;
    endfunction

    function automatic item_t tick_beat(logic [7:0] rbyte, logic rok, logic pok, logic lok);
        item_t b;
        b             = bus_beat(FUNC_TICK, 6'($urandom), 16'($urandom));
        b.reader_byte = rbyte;
        b.reader_ok   = rok;
        b.punch_ok    = pok;
        b.printer_ok  = lok;
        return b;
    endfunction

    // register traffic with ticks in between, sinks mostly willing, rare resets
    function automatic item_t random_beat();
        item_t b;
        int    pick;
        b = tick_beat(8'($urandom), $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                      $urandom_range(0, 4) != 0);
        b.reg_addr = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : any_register();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            b.func = FUNC_TICK;
        end
        else if (pick < 55)
        begin
            b.func = FUNC_WRITE;
            if (b.reg_addr == ADDR_PRS && $urandom_range(0, 1) == 1)
                b.write_data[0] = 1'b1;
        end
        else if (pick < 96)
        begin
            b.func = FUNC_READ;
        end
        else
        begin
            b.func = FUNC_RESET;
        end
        return b;
    endfunction

    // offer one beat and hold it until taken
    task automatic send_beat(item_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= b.func;
        reg_addr    <= b.reg_addr;
        write_data  <= b.write_data;
        reader_byte <= b.reader_byte;
        reader_ok   <= b.reader_ok;
        punch_ok    <= b.punch_ok;
        printer_ok  <= b.printer_ok;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int n;
        bit hold_done;
        out_stall = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                out_stall <= (n > 0);
                repeat ((n > 0) ? n : 1) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_READ;
        reg_addr    = 6'h00;
        write_data  = 16'h0000;
        reader_byte = 8'h00;
        reader_ok   = 1'b0;
        punch_ok    = 1'b0;
        printer_ok  = 1'b0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        send_beat(bus_beat(FUNC_READ, ADDR_PRS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PPS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_LPS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PRB, 16'h0000));
        // read-only masks on status writes
        send_beat(bus_beat(FUNC_WRITE, ADDR_LPS, 16'hFFFF));
        send_beat(bus_beat(FUNC_READ, ADDR_LPS, 16'h0000));
        send_beat(bus_beat(FUNC_WRITE, ADDR_PPS, 16'h0000));
        // buffer writes clear ready, reader go preloads
        send_beat(bus_beat(FUNC_WRITE, ADDR_PPB, 16'hFFFF));
        send_beat(bus_beat(FUNC_WRITE, ADDR_LPB, 16'h00A5));
        send_beat(bus_beat(FUNC_WRITE, ADDR_PRS, 16'hFFFF));
        send_beat(bus_beat(FUNC_READ, ADDR_PRS, 16'h0000));
        // fetch ok, punch refuses, printer takes its byte
        send_beat(tick_beat(8'hFF, 1'b1, 1'b0, 1'b1));
        send_beat(bus_beat(FUNC_READ, ADDR_PRB, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PPS, 16'h0000));
        // read-only buffer and unknown offsets
        send_beat(bus_beat(FUNC_WRITE, ADDR_PRB, 16'hABCD));
        send_beat(bus_beat(FUNC_WRITE, 6'o77, 16'hFFFF));
        send_beat(bus_beat(FUNC_READ, 6'o77, 16'h0000));
        send_beat(bus_beat(FUNC_READ, 6'o00, 16'h0000));
        // end of tape, punch takes, printer refuses
        send_beat(bus_beat(FUNC_WRITE, ADDR_PRS, 16'h0001));
        send_beat(bus_beat(FUNC_WRITE, ADDR_PPB, 16'h005A));
        send_beat(bus_beat(FUNC_WRITE, ADDR_LPB, 16'h003C));
        send_beat(tick_beat(8'h00, 1'b0, 1'b1, 1'b0));
        // reads while a reset is pending, then the tick that performs it
        send_beat(bus_beat(FUNC_RESET, ADDR_PRS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PRS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PPS, 16'h0000));
        send_beat(bus_beat(FUNC_READ, ADDR_PRB, 16'h0000));
        send_beat(tick_beat(8'h81, 1'b1, 1'b1, 1'b1));
        send_beat(bus_beat(FUNC_READ, ADDR_PRS, 16'h0000));

        // random traffic in blocks, some blocks with no idling at all
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i == 100)
            begin
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            send_beat(random_beat());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[paper_tape_printer_register_block_unit.f]
design/ptp_pkg.sv
design/ptp_core.sv
design/paper_tape_printer_register_block_unit.sv
test/ptp_register_checker.sv
test/tb_top.sv
